### hdl/swqe_pkg.sv
// shared constants and types for the wide segment quad expander
package swqe_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // normal vector arithmetic runs at a fixed Q1.30 scale
  localparam int NORM_SHIFT  = 30;
  localparam int NORM_BITS   = 30;
  localparam int LEN_BITS    = 31;
  localparam int SUMSQ_BITS  = 61;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW_PLANE = 3'd0,
    REG_PPM        = 3'd1,
    REG_MARGIN     = 3'd2,
    REG_MIN_U      = 3'd3,
    REG_MAX_V      = 3'd4
  } cfg_reg_t;

  localparam logic [1:0] PLANE_XZ = 2'd0;
  localparam logic [1:0] PLANE_YZ = 2'd1;

  // pipeline stage numbers, counted from the accepting edge
  localparam int ST_ZCHK = 7;
  localparam int ST_SIDE = 8;
  localparam int ST_SQ0  = 13;
  localparam int ST_SQE  = ST_SQ0 + LEN_BITS;
  localparam int ST_DV0  = ST_SQE + 1;
  localparam int ST_DVE  = ST_DV0 + LEN_BITS;
  localparam int ST_OM   = ST_DVE + 2;
  localparam int ST_OR   = ST_OM + 1;
  localparam int ST_CS   = ST_OR + 1;
  localparam int PIPE_LATENCY = ST_CS + 1;

endpackage

### hdl/swqe_mul.sv
// two-stage unsigned multiplier built from four registered partial products
module swqe_mul #(
  parameter int AW = swqe_pkg::COORD_WIDTH_DEF,
  parameter int BW = swqe_pkg::COORD_WIDTH_DEF
) (
  input  logic             clk,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] pp_ll;
  logic [AL+BH-1:0] pp_lh;
  logic [AH+BL-1:0] pp_hl;
  logic [AH+BH-1:0] pp_hh;

  always_ff @(posedge clk) begin
    pp_ll <= a[AL-1:0] * b[BL-1:0];
    pp_lh <= a[AL-1:0] * b[BW-1:BL];
    pp_hl <= a[AW-1:AL] * b[BL-1:0];
    pp_hh <= a[AW-1:AL] * b[BW-1:BL];
  end

  always_ff @(posedge clk) begin
    p <= PW'(pp_ll) + (PW'(pp_lh) << BL) + (PW'(pp_hl) << AL) + (PW'(pp_hh) << (AL + BL));
  end

endmodule

### hdl/wide_segment_quad_expander.sv
// thick line expander: 3-D segment to the four pixel corners of its rectangle
//
// Input channel: an item is taken at a rising edge with start high and busy low.
// busy is low at all times outside reset, so one segment can enter every cycle.
// Each segment is projected onto the plane picked by view_plane, mapped to
// pixels with pixels_per_meter, margin_px, min_u and max_v, and widened by
// half its depth (at least one pixel) along the unit normal.
// Result channel: done is high for one cycle with the four corners and the
// saturated flag; the receiver takes every result and cannot hold it off.
// A segment whose two pixel endpoints coincide produces no result beat.
// The throughput is one segment per cycle. The pipeline length is set by the
// square root and the two dividers, each one bit per stage.
// Configuration: a write beat on cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. The user must change registers only
// between segments; the block does not enforce it. Reset clears all in-flight
// items and loads the register defaults (plane XZ, scale 1.0, margin 0,
// origin 0, flip axis 0).
module wide_segment_quad_expander #(
  parameter int COORD_WIDTH = swqe_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = swqe_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [COORD_WIDTH-1:0]  end_a_x,
  input  logic signed [COORD_WIDTH-1:0]  end_a_y,
  input  logic signed [COORD_WIDTH-1:0]  end_a_z,
  input  logic signed [COORD_WIDTH-1:0]  end_b_x,
  input  logic signed [COORD_WIDTH-1:0]  end_b_y,
  input  logic signed [COORD_WIDTH-1:0]  end_b_z,
  input  logic        [COORD_WIDTH-2:0]  depth_m,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [swqe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]         cfg_data,
  output logic                           done,
  output logic signed [COORD_WIDTH-1:0]  corner_a_x,
  output logic signed [COORD_WIDTH-1:0]  corner_a_y,
  output logic signed [COORD_WIDTH-1:0]  corner_b_x,
  output logic signed [COORD_WIDTH-1:0]  corner_b_y,
  output logic signed [COORD_WIDTH-1:0]  corner_c_x,
  output logic signed [COORD_WIDTH-1:0]  corner_c_y,
  output logic signed [COORD_WIDTH-1:0]  corner_d_x,
  output logic signed [COORD_WIDTH-1:0]  corner_d_y,
  output logic                           saturated
);

  localparam int CW   = COORD_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int DW   = CW + 1;
  localparam int PW   = DW + CW;
  localparam int LW   = CW + 3;
  localparam int PXW  = CW + 4;
  localparam int SW   = CW + 5;
  localparam int MW   = CW + 4;
  localparam int SHW  = $clog2(MW + 1);
  localparam int NB   = swqe_pkg::NORM_BITS;
  localparam int EW   = MW + NB;
  localparam int HPW  = 2 * CW - 1;
  localparam int LB   = swqe_pkg::LEN_BITS;
  localparam int RMW  = swqe_pkg::SUMSQ_BITS + 1;
  localparam int OPW  = LB + LW;
  localparam int NSH  = swqe_pkg::NORM_SHIFT;
  localparam int ST_ZCHK = swqe_pkg::ST_ZCHK;
  localparam int ST_SIDE = swqe_pkg::ST_SIDE;
  localparam int ST_DVE  = swqe_pkg::ST_DVE;
  localparam int ST_OM   = swqe_pkg::ST_OM;
  localparam int ST_OR   = swqe_pkg::ST_OR;
  localparam int ST_CS   = swqe_pkg::ST_CS;

  localparam logic [LW-1:0]  LIM      = '1;
  localparam logic [SW-1:0]  LIM_S    = SW'(LIM);
  localparam logic [SW-1:0]  NLIM_S   = ~LIM_S + SW'(1);
  localparam logic [PW:0]    RND_PIX  = (PW + 1)'(1) << (FB - 1);
  localparam logic [HPW:0]   RND_HALF = (HPW + 1)'(1) << FB;
  localparam logic [OPW:0]   RND_OFF  = (OPW + 1)'(1) << (NSH - 1);
  localparam logic [LW-1:0]  ONE_PX   = LW'(1) << FB;
  localparam logic [CW-1:0]  PPM_RST  = CW'(1) << FB;

  typedef struct packed {
    logic [3:0][PXW-1:0] p;
    logic [LW-1:0]       half;
    logic                sat;
    logic                negx;
    logic                negy;
  } side_t;

  // configuration registers
  logic [1:0]    view_plane;
  logic [CW-1:0] pixels_per_meter;
  logic [CW-1:0] margin_px;
  logic [CW-1:0] min_u;
  logic [CW-1:0] max_v;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_plane       <= swqe_pkg::PLANE_XZ;
      pixels_per_meter <= PPM_RST;
      margin_px        <= '0;
      min_u            <= '0;
      max_v            <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (swqe_pkg::cfg_reg_t'(cfg_index))
        swqe_pkg::REG_VIEW_PLANE: view_plane       <= cfg_data[1:0];
        swqe_pkg::REG_PPM:        pixels_per_meter <= cfg_data;
        swqe_pkg::REG_MARGIN:     margin_px        <= cfg_data;
        swqe_pkg::REG_MIN_U:      min_u            <= cfg_data;
        swqe_pkg::REG_MAX_V:      max_v            <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits, one per stage
  logic vld [1:ST_CS];
  logic zero_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= ST_CS; k++) vld[k] <= 1'b0;
    end else begin
      vld[1] <= start && !busy;
      for (int k = 2; k <= ST_CS; k++) begin
        if (k == ST_ZCHK) vld[k] <= vld[k-1] && !zero_len;
        else vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: plane select and offset from the drawing origin
  logic [CW-1:0] ua, va, ub, vb;
  logic [DW-1:0] d1 [4];
  logic [CW-2:0] depth1, depth2;

  always_comb begin
    case (view_plane)
      swqe_pkg::PLANE_XZ: begin
        ua = end_a_x; va = end_a_z; ub = end_b_x; vb = end_b_z;
      end
      swqe_pkg::PLANE_YZ: begin
        ua = end_a_y; va = end_a_z; ub = end_b_y; vb = end_b_z;
      end
      default: begin
        ua = end_a_x; va = end_a_y; ub = end_b_x; vb = end_b_y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    d1[0]  <= {ua[CW-1], ua} - {min_u[CW-1], min_u};
    d1[1]  <= {max_v[CW-1], max_v} - {va[CW-1], va};
    d1[2]  <= {ub[CW-1], ub} - {min_u[CW-1], min_u};
    d1[3]  <= {max_v[CW-1], max_v} - {vb[CW-1], vb};
    depth1 <= depth_m;
  end

  // stage 2: sign and magnitude
  logic [DW-1:0] mag2 [4];
  logic [3:0]    neg2, neg3, neg4, neg5;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      neg2[i] <= d1[i][DW-1];
      mag2[i] <= d1[i][DW-1] ? (~d1[i] + DW'(1)) : d1[i];
    end
    depth2 <= depth1;
    neg3   <= neg2;
    neg4   <= neg3;
    neg5   <= neg4;
  end

  // stages 3-4: scale products
  logic [PW-1:0]  prod4 [4];
  logic [HPW-1:0] hprod4;

  for (genvar g = 0; g < 4; g++) begin : g_pix_mul
    swqe_mul #(.AW(DW), .BW(CW)) u_mul (
      .clk (clk),
      .a   (mag2[g]),
      .b   (pixels_per_meter),
      .p   (prod4[g])
    );
  end

  swqe_mul #(.AW(CW - 1), .BW(CW)) u_half_mul (
    .clk (clk),
    .a   (depth2),
    .b   (pixels_per_meter),
    .p   (hprod4)
  );

  // stage 5: round, shift and clamp to the internal limit
  logic [PW:0]   tv [4];
  logic [HPW:0]  hv;
  logic [LW-1:0] term5 [4];
  logic [3:0]    psat5;
  logic [LW-1:0] half5;
  logic          hsat5;

  always_comb begin
    for (int i = 0; i < 4; i++) tv[i] = ({1'b0, prod4[i]} + RND_PIX) >> FB;
    hv = ({1'b0, hprod4} + RND_HALF) >> (FB + 1);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (tv[i] > (PW + 1)'(LIM)) begin
        term5[i] <= LIM;
        psat5[i] <= 1'b1;
      end else begin
        term5[i] <= tv[i][LW-1:0];
        psat5[i] <= 1'b0;
      end
    end
    if (hv > (HPW + 1)'(LIM)) begin
      half5 <= LIM;
      hsat5 <= 1'b1;
    end else begin
      half5 <= hv[LW-1:0];
      hsat5 <= 1'b0;
    end
  end

  // stage 6: add margin, clamp pixel points, floor the half-width
  logic [SW-1:0]  sum6 [4];
  logic [PXW-1:0] p6 [4];
  logic [LW-1:0]  half6;
  logic           sat6;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum6[i] = {5'b0, margin_px} +
                (neg5[i] ? (~{2'b00, term5[i]} + SW'(1)) : {2'b00, term5[i]});
    end
  end

  always_ff @(posedge clk) begin
    logic any_clamp;
    any_clamp = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if ($signed(sum6[i]) > $signed(LIM_S)) begin
        p6[i] <= LIM_S[PXW-1:0];
        any_clamp = 1'b1;
      end else if ($signed(sum6[i]) < $signed(NLIM_S)) begin
        p6[i] <= NLIM_S[PXW-1:0];
        any_clamp = 1'b1;
      end else begin
        p6[i] <= sum6[i][PXW-1:0];
      end
    end
    half6 <= (half5 < ONE_PX) ? ONE_PX : half5;
    sat6  <= any_clamp || (|psat5) || hsat5;
  end

  // stage 7: direction, zero-length segments are dropped here
  logic [SW-1:0]  dx7, dy7;
  logic [PXW-1:0] p7 [4];
  logic [LW-1:0]  half7;
  logic           sat7;

  assign zero_len = (p6[2] == p6[0]) && (p6[3] == p6[1]);

  always_ff @(posedge clk) begin
    dx7   <= {p6[2][PXW-1], p6[2]} - {p6[0][PXW-1], p6[0]};
    dy7   <= {p6[3][PXW-1], p6[3]} - {p6[1][PXW-1], p6[1]};
    p7    <= p6;
    half7 <= half6;
    sat7  <= sat6;
  end

  // stage 8: magnitudes, side data enters its delay line
  side_t         sd [ST_SIDE:ST_OR];
  logic [MW-1:0] ax8, ay8;
  logic [SW-1:0] adx7, ady7;

  assign adx7 = dx7[SW-1] ? (~dx7 + SW'(1)) : dx7;
  assign ady7 = dy7[SW-1] ? (~dy7 + SW'(1)) : dy7;

  always_ff @(posedge clk) begin
    ax8 <= adx7[MW-1:0];
    ay8 <= ady7[MW-1:0];
    for (int i = 0; i < 4; i++) sd[ST_SIDE].p[i] <= p7[i];
    sd[ST_SIDE].half <= half7;
    sd[ST_SIDE].sat  <= sat7;
    sd[ST_SIDE].negx <= !dy7[SW-1] && (dy7 != '0);
    sd[ST_SIDE].negy <= dx7[SW-1];
  end

  for (genvar k = ST_SIDE + 1; k <= ST_OR; k++) begin : g_side
    always_ff @(posedge clk) begin
      sd[k] <= sd[k-1];
    end
  end

  // stage 9: leading one of the larger magnitude
  logic [MW-1:0]  mx8;
  logic [SHW-1:0] sh8, sh9;
  logic [MW-1:0]  ax9, ay9;

  always_comb begin
    mx8 = (ax8 > ay8) ? ax8 : ay8;
    sh8 = '0;
    for (int i = 0; i < MW; i++) begin
      if (mx8[i]) sh8 = SHW'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    sh9 <= sh8;
    ax9 <= ax8;
    ay9 <= ay8;
  end

  // stage 10: normalize so the larger lies in [2^29, 2^30)
  logic [EW-1:0] ea9, eb9;
  logic [NB-1:0] na10, nb10, na11, nb11, na12, nb12;

  assign ea9 = {ax9, {NB{1'b0}}} >> sh9;
  assign eb9 = {ay9, {NB{1'b0}}} >> sh9;

  always_ff @(posedge clk) begin
    na10 <= ea9[NB-1:0];
    nb10 <= eb9[NB-1:0];
    na11 <= na10;
    nb11 <= nb10;
    na12 <= na11;
    nb12 <= nb11;
  end

  // stages 11-12: squares
  logic [2*NB-1:0] sqa12, sqb12;

  swqe_mul #(.AW(NB), .BW(NB)) u_sqa (.clk(clk), .a(na10), .b(na10), .p(sqa12));
  swqe_mul #(.AW(NB), .BW(NB)) u_sqb (.clk(clk), .a(nb10), .b(nb10), .p(sqb12));

  // square root, one result bit per stage
  logic [RMW-1:0] rm [0:LB];
  logic [LB-1:0]  rt [1:LB];
  logic [NB-1:0]  sa [0:LB];
  logic [NB-1:0]  sb [0:LB];

  always_ff @(posedge clk) begin
    rm[0] <= RMW'(sqa12) + RMW'(sqb12);
    sa[0] <= na12;
    sb[0] <= nb12;
  end

  for (genvar j = 0; j < LB; j++) begin : g_sqrt
    localparam int I = LB - 1 - j;
    logic [LB-1:0]  rtp;
    logic [RMW-1:0] dsq;
    logic           take;

    if (j == 0) begin : g_first
      assign rtp = '0;
    end else begin : g_next
      assign rtp = rt[j];
    end

    assign dsq  = (RMW'(rtp) << (I + 1)) + (RMW'(1) << (2 * I));
    assign take = rm[j] >= dsq;

    always_ff @(posedge clk) begin
      rm[j+1] <= take ? (rm[j] - dsq) : rm[j];
      rt[j+1] <= take ? (rtp | (LB'(1) << I)) : rtp;
      sa[j+1] <= sa[j];
      sb[j+1] <= sb[j];
    end
  end

  // two rounding dividers sharing the length, one quotient bit per stage
  logic [LB-1:0]  ln  [0:LB];
  logic [RMW-1:0] drx [0:LB];
  logic [RMW-1:0] dry [0:LB];
  logic [LB-1:0]  qx  [1:LB];
  logic [LB-1:0]  qy  [1:LB];

  always_ff @(posedge clk) begin
    ln[0]  <= rt[LB];
    drx[0] <= (RMW'(sb[LB]) << NSH) + RMW'(rt[LB] >> 1);
    dry[0] <= (RMW'(sa[LB]) << NSH) + RMW'(rt[LB] >> 1);
  end

  for (genvar j = 0; j < LB; j++) begin : g_div
    localparam int I = LB - 1 - j;
    logic [LB-1:0]  qxp, qyp;
    logic [RMW-1:0] dd;
    logic           tx, ty;

    if (j == 0) begin : g_first
      assign qxp = '0;
      assign qyp = '0;
    end else begin : g_next
      assign qxp = qx[j];
      assign qyp = qy[j];
    end

    assign dd = RMW'(ln[j]) << I;
    assign tx = drx[j] >= dd;
    assign ty = dry[j] >= dd;

    always_ff @(posedge clk) begin
      ln[j+1]  <= ln[j];
      drx[j+1] <= tx ? (drx[j] - dd) : drx[j];
      dry[j+1] <= ty ? (dry[j] - dd) : dry[j];
      qx[j+1]  <= tx ? (qxp | (LB'(1) << I)) : qxp;
      qy[j+1]  <= ty ? (qyp | (LB'(1) << I)) : qyp;
    end
  end

  // offset products, normal times half-width
  logic [OPW-1:0] opx, opy;

  swqe_mul #(.AW(LB), .BW(LW)) u_offx (
    .clk (clk), .a(qx[LB]), .b(sd[ST_DVE].half), .p(opx)
  );
  swqe_mul #(.AW(LB), .BW(LW)) u_offy (
    .clk (clk), .a(qy[LB]), .b(sd[ST_DVE].half), .p(opy)
  );

  // round the offsets back to pixels
  logic [OPW:0]  ovx, ovy;
  logic [LW-1:0] omx, omy;
  logic          osat;

  assign ovx = ({1'b0, opx} + RND_OFF) >> NSH;
  assign ovy = ({1'b0, opy} + RND_OFF) >> NSH;

  always_ff @(posedge clk) begin
    omx  <= (ovx > (OPW + 1)'(LIM)) ? LIM : ovx[LW-1:0];
    omy  <= (ovy > (OPW + 1)'(LIM)) ? LIM : ovy[LW-1:0];
    osat <= (ovx > (OPW + 1)'(LIM)) || (ovy > (OPW + 1)'(LIM));
  end

  // corner sums
  logic [SW-1:0] osx, osy;
  logic [SW-1:0] pe [4];
  logic [SW-1:0] cs [8];
  logic          sat_cs;

  always_comb begin
    osx = sd[ST_OR].negx ? (~{2'b00, omx} + SW'(1)) : {2'b00, omx};
    osy = sd[ST_OR].negy ? (~{2'b00, omy} + SW'(1)) : {2'b00, omy};
    for (int i = 0; i < 4; i++) pe[i] = {sd[ST_OR].p[i][PXW-1], sd[ST_OR].p[i]};
  end

  always_ff @(posedge clk) begin
    cs[0]  <= pe[0] + osx;
    cs[1]  <= pe[1] + osy;
    cs[2]  <= pe[0] - osx;
    cs[3]  <= pe[1] - osy;
    cs[4]  <= pe[2] - osx;
    cs[5]  <= pe[3] - osy;
    cs[6]  <= pe[2] + osx;
    cs[7]  <= pe[3] + osy;
    sat_cs <= sd[ST_OR].sat || osat;
  end

  // output clamp and result register
  logic [CW-1:0] co [8];
  logic [7:0]    ovf;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ovf[i] = !((&cs[i][SW-1:CW-1]) || !(|cs[i][SW-1:CW-1]));
      if (ovf[i]) co[i] = cs[i][SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      else co[i] = cs[i][CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[ST_CS];
    end
  end

  always_ff @(posedge clk) begin
    corner_a_x <= co[0];
    corner_a_y <= co[1];
    corner_b_x <= co[2];
    corner_b_y <= co[3];
    corner_c_x <= co[4];
    corner_c_y <= co[5];
    corner_d_x <= co[6];
    corner_d_y <= co[7];
    saturated  <= sat_cs || (|ovf);
  end

endmodule

### hdl/swqe_checker.sv
// port-level checks for the wide segment quad expander, bound to the top level
module swqe_checker #(
  parameter int CW = swqe_pkg::COORD_WIDTH_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic signed [CW-1:0] end_a_x,
  input logic signed [CW-1:0] end_a_y,
  input logic signed [CW-1:0] end_a_z,
  input logic signed [CW-1:0] end_b_x,
  input logic signed [CW-1:0] end_b_y,
  input logic signed [CW-1:0] end_b_z,
  input logic                 done,
  input logic signed [CW-1:0] corner_a_x,
  input logic signed [CW-1:0] corner_a_y,
  input logic signed [CW-1:0] corner_b_x,
  input logic signed [CW-1:0] corner_b_y,
  input logic signed [CW-1:0] corner_c_x,
  input logic signed [CW-1:0] corner_c_y,
  input logic signed [CW-1:0] corner_d_x,
  input logic signed [CW-1:0] corner_d_y,
  input logic                 saturated
);

  localparam int LAT = swqe_pkg::PIPE_LATENCY;

  logic signed [CW:0] wab_x, wdc_x, wab_y, wdc_y;

  assign wab_x = {corner_a_x[CW-1], corner_a_x} - {corner_b_x[CW-1], corner_b_x};
  assign wdc_x = {corner_d_x[CW-1], corner_d_x} - {corner_c_x[CW-1], corner_c_x};
  assign wab_y = {corner_a_y[CW-1], corner_a_y} - {corner_b_y[CW-1], corner_b_y};
  assign wdc_y = {corner_d_y[CW-1], corner_d_y} - {corner_c_y[CW-1], corner_c_y};

  // every result beat traces back to a segment beat a fixed latency earlier
  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result beat without a matching segment beat");

  // coincident 3-D endpoints always project to one pixel and give no result
  a_point_dropped: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(start && !busy && end_a_x == end_b_x && end_a_y == end_b_y &&
                    end_a_z == end_b_z, LAT))
    else $error("degenerate segment produced a result");

  // both ends are widened by the same offset
  a_parallel_x: assert property (@(posedge clk) disable iff (rst)
    done && !saturated |-> wab_x == wdc_x)
    else $error("end offsets differ in x");

  a_parallel_y: assert property (@(posedge clk) disable iff (rst)
    done && !saturated |-> wab_y == wdc_y)
    else $error("end offsets differ in y");

  // width is at least one pixel, so the two corners at one end never coincide
  a_nonzero_width: assert property (@(posedge clk) disable iff (rst)
    done && !saturated |-> (corner_a_x != corner_b_x) || (corner_a_y != corner_b_y))
    else $error("quad collapsed to zero width");

endmodule

bind wide_segment_quad_expander swqe_checker #(.CW(COORD_WIDTH)) u_swqe_checker (.*);
